[design/c2s_pkg.sv]
// Shared types, widths and the arctangent table for the Cartesian to
// spherical converter. No dependencies.
`default_nettype none

package c2s_pkg;

   localparam int COORD_W = 20;
   localparam int ROOT_W  = 30;
   localparam int RAD_W   = 2 * ROOT_W;
   localparam int REM_W   = ROOT_W + 2;
   localparam int VEC_W   = 33;
   localparam int ACC_W   = 27;
   localparam int ANG_W   = ACC_W - 7;
   localparam int AZ_W    = 17;
   localparam int EL_W    = 16;
   localparam int RANGE_W = 20;
   localparam int MAX_STAGES = 32;
   localparam int DEFAULT_STAGES = 16;

   localparam logic signed [ACC_W-1:0] DEG180_Q16 = ACC_W'(11796480);
   localparam logic signed [ANG_W-1:0] AZ_LIMIT   = ANG_W'(46080);
   localparam logic signed [ANG_W-1:0] EL_LIMIT   = ANG_W'(23040);

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } c2s_point_type;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } c2s_sqrt_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] vx;
      logic signed [VEC_W-1:0] vy;
      logic signed [ACC_W-1:0] acc;
   } c2s_vec_type;

   typedef struct packed {
      logic [RANGE_W-1:0] range;
      logic               origin;
      logic               on_axis;
      logic               z_neg;
   } c2s_meta_type;

   // atan(2^-i) in units of 2^-16 degree.
   function automatic logic signed [ACC_W-1:0] atan_q16(input int i);
      logic signed [ACC_W-1:0] t;
      case (i)
         0:  t = ACC_W'(2949120);
         1:  t = ACC_W'(1740967);
         2:  t = ACC_W'(919879);
         3:  t = ACC_W'(466945);
         4:  t = ACC_W'(234379);
         5:  t = ACC_W'(117304);
         6:  t = ACC_W'(58666);
         7:  t = ACC_W'(29335);
         8:  t = ACC_W'(14668);
         9:  t = ACC_W'(7334);
         10: t = ACC_W'(3667);
         11: t = ACC_W'(1833);
         12: t = ACC_W'(917);
         13: t = ACC_W'(458);
         14: t = ACC_W'(229);
         15: t = ACC_W'(115);
         16: t = ACC_W'(57);
         17: t = ACC_W'(29);
         18: t = ACC_W'(14);
         19: t = ACC_W'(7);
         20: t = ACC_W'(4);
         21: t = ACC_W'(2);
         22: t = ACC_W'(1);
         default: t = '0;
      endcase
      return t;
   endfunction

   // Round to 1/256 degree, halves up, then clamp to +-lim.
   function automatic logic signed [ANG_W-1:0] round_sat(
      input logic signed [ACC_W-1:0] acc,
      input logic signed [ANG_W-1:0] lim
   );
      logic signed [ACC_W:0]   s;
      logic signed [ANG_W-1:0] r;
      s = {acc[ACC_W-1], acc} + (ACC_W+1)'(128);
      r = s[ACC_W:8];
      if (r > lim) begin
         r = lim;
      end else if (r < -lim) begin
         r = -lim;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[design/c2s_sqrt_cell.sv]
// One digit-by-digit square root cell: two lanes, one root bit each per beat.
// Depends on c2s_pkg.
`default_nettype none

module c2s_sqrt_cell
   import c2s_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output      logic                 in_ready,
   input  wire c2s_sqrt_type [1:0]   in_lane,
   input  wire c2s_point_type        in_point,
   output      logic                 out_valid,
   input  wire logic                 out_ready,
   output      c2s_sqrt_type [1:0]   out_lane,
   output      c2s_point_type        out_point
);

   logic               valid_ff;
   c2s_sqrt_type [1:0] lane_ff;
   c2s_sqrt_type [1:0] lane_in;
   c2s_point_type      point_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;
   assign out_point = point_ff;

   always_comb begin
      logic [REM_W+1:0] r4    [2];
      logic [REM_W+1:0] trial [2];
      for (int k = 0; k < 2; k++) begin
         r4[k]    = {in_lane[k].rem, in_lane[k].rad[RAD_W-1 -: 2]};
         trial[k] = {2'b00, in_lane[k].root, 2'b01};
         lane_in[k].rad = {in_lane[k].rad[RAD_W-3:0], 2'b00};
         if (r4[k] >= trial[k]) begin
            lane_in[k].rem  = REM_W'(r4[k] - trial[k]);
            lane_in[k].root = {in_lane[k].root[ROOT_W-2:0], 1'b1};
         end else begin
            lane_in[k].rem  = REM_W'(r4[k]);
            lane_in[k].root = {in_lane[k].root[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         lane_ff  <= lane_in;
         point_ff <= in_point;
      end
   end

endmodule

`default_nettype wire

[design/c2s_cordic_cell.sv]
// One vectoring CORDIC stage for the azimuth and elevation lanes.
// Depends on c2s_pkg.
`default_nettype none

module c2s_cordic_cell
   import c2s_pkg::*;
#(
   parameter int STAGE = 0
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output      logic                in_ready,
   input  wire c2s_vec_type [1:0]   in_lane,
   input  wire c2s_meta_type        in_meta,
   output      logic                out_valid,
   input  wire logic                out_ready,
   output      c2s_vec_type [1:0]   out_lane,
   output      c2s_meta_type        out_meta
);

   localparam logic signed [ACC_W-1:0] ANGLE = atan_q16(STAGE);

   logic              valid_ff;
   c2s_vec_type [1:0] lane_ff;
   c2s_vec_type [1:0] lane_in;
   c2s_meta_type      meta_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;
   assign out_meta  = meta_ff;

   // A positive y turns the vector clockwise and adds the stage angle.
   always_comb begin
      logic signed [VEC_W-1:0] dx [2];
      logic signed [VEC_W-1:0] dy [2];
      for (int k = 0; k < 2; k++) begin
         dx[k] = in_lane[k].vy >>> STAGE;
         dy[k] = in_lane[k].vx >>> STAGE;
         if (in_lane[k].vy > 0) begin
            lane_in[k].vx  = in_lane[k].vx + dx[k];
            lane_in[k].vy  = in_lane[k].vy - dy[k];
            lane_in[k].acc = in_lane[k].acc + ANGLE;
         end else begin
            lane_in[k].vx  = in_lane[k].vx - dx[k];
            lane_in[k].vy  = in_lane[k].vy + dy[k];
            lane_in[k].acc = in_lane[k].acc - ANGLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         lane_ff <= lane_in;
         meta_ff <= in_meta;
      end
   end

endmodule

`default_nettype wire

[design/cartesian_to_spherical_core.sv]
// Top level of the Cartesian to spherical converter: squaring stage, square
// root cell chain, CORDIC cell chain and output rounding. Uses c2s_pkg,
// c2s_sqrt_cell and c2s_cordic_cell.
//
// Usage: a point (req_x_mm, req_y_mm, req_z_mm) is taken on each beat of the
// req_ channel, and one result beat leaves on the rsp_ channel with the
// rounded range, azimuth and elevation in 1/256 degree, and origin_point.
// Results leave in the order the points came in.
// The stages are one squaring stage, thirty root cells that each produce one
// root bit, one setup stage, one cell per CORDIC stage (up to MAX_STAGES) and
// the output register. Throughput is one point per cycle while rsp_ready is
// high; every cell holds one point.
// Each cell moves on whenever the cell after it is empty or moving, so when
// the receiver stalls the points close up behind the output register and
// req_ready falls only once every cell is full. Nothing is dropped.
// Reset clears every cell's valid bit; the pipeline is empty afterwards.
`default_nettype none

module cartesian_to_spherical_core
   import c2s_pkg::*;
#(
   parameter int CORDIC_STAGES = DEFAULT_STAGES
)
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic signed [COORD_W-1:0]   req_x_mm,
   input  wire logic signed [COORD_W-1:0]   req_y_mm,
   input  wire logic signed [COORD_W-1:0]   req_z_mm,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      logic signed [AZ_W-1:0]      rsp_azimuth,
   output      logic signed [EL_W-1:0]      rsp_elevation,
   output      logic [RANGE_W-1:0]          rsp_range_mm,
   output      logic                        rsp_origin_point
);

   localparam int NCELLS = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;

   // Squaring stage.
   logic                  front_valid_ff;
   c2s_sqrt_type [1:0]    front_lane_ff;
   c2s_point_type         front_point_ff;
   logic signed [2*COORD_W-1:0] xsq, ysq, zsq;
   logic [2*COORD_W-1:0]  rho2;
   logic [2*COORD_W:0]    nsum;

   // Root chain; lane 0 is the range, lane 1 the horizontal distance.
   logic               sq_valid [ROOT_W+1];
   logic               sq_ready [ROOT_W+1];
   c2s_sqrt_type [1:0] sq_lane  [ROOT_W+1];
   c2s_point_type      sq_point [ROOT_W+1];

   // Setup stage.
   logic              prep_valid_ff;
   c2s_vec_type [1:0] prep_lane_ff;
   c2s_vec_type [1:0] prep_lane_in;
   c2s_meta_type      prep_meta_ff;
   c2s_meta_type      prep_meta_in;
   logic              prep_ready;

   // CORDIC chain; lane 0 is the azimuth, lane 1 the elevation.
   logic              cv_valid [NCELLS+1];
   logic              cv_ready [NCELLS+1];
   c2s_vec_type [1:0] cv_lane  [NCELLS+1];
   c2s_meta_type      cv_meta  [NCELLS+1];

   // Output register.
   logic                    out_valid_ff;
   logic signed [AZ_W-1:0]  az_ff;
   logic signed [EL_W-1:0]  el_ff;
   logic [RANGE_W-1:0]      range_ff;
   logic                    origin_ff;
   logic                    out_ready;
   logic signed [ANG_W-1:0] az_round, el_round;

   assign xsq  = req_x_mm * req_x_mm;
   assign ysq  = req_y_mm * req_y_mm;
   assign zsq  = req_z_mm * req_z_mm;
   assign rho2 = xsq + ysq;
   assign nsum = {1'b0, rho2} + {1'b0, zsq};

   assign req_ready = !front_valid_ff || sq_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (req_ready) begin
         front_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         front_lane_ff[0].rad  <= RAD_W'(nsum);
         front_lane_ff[0].rem  <= '0;
         front_lane_ff[0].root <= '0;
         front_lane_ff[1].rad  <= {rho2, {(RAD_W-2*COORD_W){1'b0}}};
         front_lane_ff[1].rem  <= '0;
         front_lane_ff[1].root <= '0;
         front_point_ff.x      <= req_x_mm;
         front_point_ff.y      <= req_y_mm;
         front_point_ff.z      <= req_z_mm;
      end
   end

   assign sq_valid[0] = front_valid_ff;
   assign sq_lane[0]  = front_lane_ff;
   assign sq_point[0] = front_point_ff;

   for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
      c2s_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_valid[g]),
         .in_ready  (sq_ready[g]),
         .in_lane   (sq_lane[g]),
         .in_point  (sq_point[g]),
         .out_valid (sq_valid[g+1]),
         .out_ready (sq_ready[g+1]),
         .out_lane  (sq_lane[g+1]),
         .out_point (sq_point[g+1])
      );
   end

   assign sq_ready[ROOT_W] = prep_ready;
   assign prep_ready       = !prep_valid_ff || cv_ready[0];

   // Range rounds up when the remainder exceeds the root. The azimuth vector
   // is folded into the right half plane, starting from +-180 degrees.
   always_comb begin
      c2s_point_type           p;
      c2s_sqrt_type            rn;
      c2s_sqrt_type            rr;
      logic signed [VEC_W-1:0] ax, ay;
      p  = sq_point[ROOT_W];
      rn = sq_lane[ROOT_W][0];
      rr = sq_lane[ROOT_W][1];
      ax = {{(VEC_W-COORD_W-10){p.x[COORD_W-1]}}, p.x, 10'b0};
      ay = {{(VEC_W-COORD_W-10){p.y[COORD_W-1]}}, p.y, 10'b0};
      if (p.x < 0) begin
         prep_lane_in[0].vx  = -ax;
         prep_lane_in[0].vy  = -ay;
         prep_lane_in[0].acc = (p.y >= 0) ? DEG180_Q16 : -DEG180_Q16;
      end else begin
         prep_lane_in[0].vx  = ax;
         prep_lane_in[0].vy  = ay;
         prep_lane_in[0].acc = '0;
      end
      prep_lane_in[1].vx  = VEC_W'(rr.root);
      prep_lane_in[1].vy  = {{(VEC_W-COORD_W-10){p.z[COORD_W-1]}}, p.z, 10'b0};
      prep_lane_in[1].acc = '0;
      prep_meta_in.range  = rn.root[RANGE_W-1:0] +
                            RANGE_W'((REM_W)'(rn.rem) > (REM_W)'(rn.root));
      prep_meta_in.origin  = (rn.root == '0);
      prep_meta_in.on_axis = (rr.root == '0);
      prep_meta_in.z_neg   = p.z[COORD_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (prep_ready) begin
         prep_valid_ff <= sq_valid[ROOT_W];
      end
      if (sq_valid[ROOT_W] && prep_ready) begin
         prep_lane_ff <= prep_lane_in;
         prep_meta_ff <= prep_meta_in;
      end
   end

   assign cv_valid[0] = prep_valid_ff;
   assign cv_lane[0]  = prep_lane_ff;
   assign cv_meta[0]  = prep_meta_ff;

   for (genvar g = 0; g < NCELLS; g++) begin : g_cordic
      c2s_cordic_cell #(
         .STAGE (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cv_valid[g]),
         .in_ready  (cv_ready[g]),
         .in_lane   (cv_lane[g]),
         .in_meta   (cv_meta[g]),
         .out_valid (cv_valid[g+1]),
         .out_ready (cv_ready[g+1]),
         .out_lane  (cv_lane[g+1]),
         .out_meta  (cv_meta[g+1])
      );
   end

   assign out_ready        = !out_valid_ff || rsp_ready;
   assign cv_ready[NCELLS] = out_ready;
   assign az_round = round_sat(cv_lane[NCELLS][0].acc, AZ_LIMIT);
   assign el_round = round_sat(cv_lane[NCELLS][1].acc, EL_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= cv_valid[NCELLS];
      end
      if (cv_valid[NCELLS] && out_ready) begin
         range_ff  <= cv_meta[NCELLS].range;
         origin_ff <= cv_meta[NCELLS].origin;
         priority if (cv_meta[NCELLS].origin) begin
            az_ff <= '0;
            el_ff <= '0;
         end else if (cv_meta[NCELLS].on_axis) begin
            az_ff <= '0;
            el_ff <= cv_meta[NCELLS].z_neg ? -EL_W'(EL_LIMIT) : EL_W'(EL_LIMIT);
         end else begin
            az_ff <= az_round[AZ_W-1:0];
            el_ff <= el_round[EL_W-1:0];
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_azimuth      = az_ff;
   assign rsp_elevation    = el_ff;
   assign rsp_range_mm     = range_ff;
   assign rsp_origin_point = origin_ff;

   a_origin_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_origin_point |->
         rsp_azimuth == '0 && rsp_elevation == '0 && rsp_range_mm == '0)
      else $error("origin beat carries nonzero fields");

   a_range_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_origin_point |-> rsp_range_mm != '0)
      else $error("nonorigin point with zero range");

   a_az_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_azimuth <= AZ_W'(AZ_LIMIT)) && (rsp_azimuth >= -AZ_W'(AZ_LIMIT)))
      else $error("azimuth out of range");

   a_el_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_elevation <= EL_W'(EL_LIMIT)) && (rsp_elevation >= -EL_W'(EL_LIMIT)))
      else $error("elevation out of range");

   a_front_full_stall: assert property (@(posedge clock) disable iff (reset)
      front_valid_ff && !sq_ready[0] |=> front_valid_ff)
      else $error("squaring stage lost a point while stalled");

endmodule

`default_nettype wire

[sim/cartesian_to_spherical_checker.sv]
// Scoreboard for the Cartesian to spherical converter: it watches both channels,
// predicts each point's result and compares it field by field. Depends on c2s_pkg.
`timescale 1ns / 100ps

module cartesian_to_spherical_checker
   import c2s_pkg::*;
#(
   parameter int CORDIC_STAGES = DEFAULT_STAGES
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic signed [COORD_W-1:0] req_x_mm,
   input  logic signed [COORD_W-1:0] req_y_mm,
   input  logic signed [COORD_W-1:0] req_z_mm,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [AZ_W-1:0]    rsp_azimuth,
   input  logic signed [EL_W-1:0]    rsp_elevation,
   input  logic [RANGE_W-1:0]        rsp_range_mm,
   input  logic                      rsp_origin_point,
   output int                        mismatches,
   output int                        outstanding
);

   typedef struct {
      logic signed [AZ_W-1:0] azimuth;
      logic signed [EL_W-1:0] elevation;
      logic [RANGE_W-1:0]     range_mm;
      logic                   origin_point;
   } spherical_point_type;

   localparam longint HALF_TURN_Q16 = 11796480;
   localparam longint AZ_MAX = 46080;
   localparam longint EL_MAX = 23040;

   longint arctan_q16 [32] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0,
      0, 0, 0, 0, 0, 0, 0, 0};

   spherical_point_type expected_points [$];

   function automatic bit [63:0] floor_sqrt(bit [63:0] n);
      bit [63:0] root;
      bit [63:0] probe;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > n) probe = probe >> 2;
      while (probe != 0) begin
         if (n >= root + probe) begin
            n = n - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // Vectoring rotation toward the positive x axis, summing the turned angle.
   function automatic longint vector_angle(longint vx, longint vy, longint acc);
      longint dx;
      longint dy;
      for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (vy > 0) begin
            vx += dx;
            vy -= dy;
            acc += arctan_q16[i];
         end else begin
            vx -= dx;
            vy += dy;
            acc -= arctan_q16[i];
         end
      end
      return acc;
   endfunction

   function automatic longint round_clamp(longint acc, longint lim);
      longint r;
      r = (acc + 128) >>> 8;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic spherical_point_type predict_point(longint x, longint y, longint z);
      spherical_point_type p;
      bit [63:0] planar_sq;
      bit [63:0] total_sq;
      bit [63:0] span;
      longint ax;
      longint ay;
      longint acc0;
      longint az;
      longint el;
      planar_sq = x * x + y * y;
      total_sq = planar_sq + z * z;
      span = floor_sqrt(total_sq);
      if (total_sq - span * span > span) span++;
      if (span > 64'hFFFFF) span = 64'hFFFFF;
      az = 0;
      el = 0;
      p.origin_point = (x == 0 && y == 0 && z == 0);
      if (p.origin_point) begin
         span = 0;
      end else if (planar_sq == 0) begin
         el = (z > 0) ? EL_MAX : -EL_MAX;
      end else begin
         ax = x * 1024;
         ay = y * 1024;
         acc0 = 0;
         if (x < 0) begin
            ax = -ax;
            ay = -ay;
            acc0 = (y >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
         end
         az = round_clamp(vector_angle(ax, ay, acc0), AZ_MAX);
         el = round_clamp(vector_angle(longint'(floor_sqrt(planar_sq << 20)), z * 1024, 0),
                          EL_MAX);
      end
      p.azimuth = az[AZ_W-1:0];
      p.elevation = el[EL_W-1:0];
      p.range_mm = span[RANGE_W-1:0];
      return p;
   endfunction

   initial begin
      mismatches = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      spherical_point_type want;
      if (!reset && req_valid && req_ready) begin
         expected_points.push_back(predict_point(req_x_mm, req_y_mm, req_z_mm));
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            $error("result beat with no point outstanding");
            mismatches++;
         end else begin
            want = expected_points.pop_front();
            if (rsp_azimuth !== want.azimuth) begin
               $error("azimuth: expected %0d, got %0d", want.azimuth, rsp_azimuth);
               mismatches++;
            end
            if (rsp_elevation !== want.elevation) begin
               $error("elevation: expected %0d, got %0d", want.elevation, rsp_elevation);
               mismatches++;
            end
            if (rsp_range_mm !== want.range_mm) begin
               $error("range_mm: expected %0d, got %0d", want.range_mm, rsp_range_mm);
               mismatches++;
            end
            if (rsp_origin_point !== want.origin_point) begin
               $error("origin_point: expected %0d, got %0d", want.origin_point,
                      rsp_origin_point);
               mismatches++;
            end
         end
      end
      outstanding = expected_points.size();
   end

endmodule

[sim/cartesian_to_spherical_core_tb.sv]
// Testbench top for the Cartesian to spherical converter: drives points and
// flow control, and gives the verdict. Depends on c2s_pkg, the core and the checker.
`timescale 1ns / 100ps

module cartesian_to_spherical_core_tb;
   import c2s_pkg::*;

   localparam int STAGES = DEFAULT_STAGES;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam logic signed [COORD_W-1:0] C_MAX = 524287;
   localparam logic signed [COORD_W-1:0] C_MIN = -524288;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [COORD_W-1:0] req_x_mm = '0;
   logic signed [COORD_W-1:0] req_y_mm = '0;
   logic signed [COORD_W-1:0] req_z_mm = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [AZ_W-1:0] rsp_azimuth;
   logic signed [EL_W-1:0] rsp_elevation;
   logic [RANGE_W-1:0] rsp_range_mm;
   logic rsp_origin_point;
   int mismatches;
   int outstanding;

   int phase = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int cycle_count = 0;

   cartesian_to_spherical_core #(.CORDIC_STAGES(STAGES)) u_top (.*);

   cartesian_to_spherical_checker #(.CORDIC_STAGES(STAGES)) u_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // The receiver owns its long hold-off so the pipeline fills and backs up.
   always @(posedge clock) begin
      int hold_left;
      bit hold_done;
      if (phase == 1 && !hold_done) begin
         hold_done = 1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic send_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                             logic signed [COORD_W-1:0] z);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_x_mm <= x;
      req_y_mm <= y;
      req_z_mm <= z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic logic signed [COORD_W-1:0] pick_coord();
      logic signed [COORD_W-1:0] v;
      case ($urandom_range(5))
         0: v = C_MAX;
         1: v = C_MIN;
         2: v = COORD_W'(int'($urandom_range(16)) - 8);
         3: v = COORD_W'(int'($urandom_range(1023)) - 512);
         default: v = COORD_W'($urandom);
      endcase
      if ($urandom_range(5) == 0) v = COORD_W'($urandom);
      return v;
   endfunction

   task automatic send_random(int count);
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      repeat (count) begin
         x = pick_coord();
         y = pick_coord();
         z = pick_coord();
         case ($urandom_range(19))
            0: begin x = '0; y = '0; end
            1: begin x = '0; y = '0; z = '0; end
            2: y = '0;
            3: x = '0;
            default: ;
         endcase
         send_point(x, y, z);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Origin, the z axis, axis crossings, the half-turn seam and corners.
      send_point(0, 0, 0);
      send_point(0, 0, 1);
      send_point(0, 0, -1);
      send_point(0, 0, C_MAX);
      send_point(0, 0, C_MIN);
      send_point(1, 0, 0);
      send_point(-1, 0, 0);
      send_point(0, 1, 0);
      send_point(0, -1, 0);
      send_point(-5, 0, 3);
      send_point(-5, -1, 3);
      send_point(-5, 1, -3);
      send_point(C_MAX, C_MAX, C_MAX);
      send_point(C_MIN, C_MIN, C_MIN);
      send_point(C_MIN, C_MAX, C_MIN);
      send_point(C_MAX, C_MIN, C_MAX);
      send_point(C_MIN, 0, 0);
      send_point(0, C_MIN, C_MAX);
      send_point(-1, -1, -1);
      send_point(1, 1, 1);
      send_point(C_MAX, 1, -1);
      send_point(C_MIN, -1, 1);

      send_random(400);
      phase = 1;
      send_random(350);
      phase = 2;
      sender_idle_pct = 71;
      send_random(380);
      phase = 3;
      sender_idle_pct = 0;
      receiver_stall_pct = 71;
      send_random(380);
      phase = 4;
      sender_idle_pct = 14;
      receiver_stall_pct = 14;
      send_random(380);
      req_valid <= 1'b0;

      // Let the checker record the last accepted beat before looking at its count.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (STAGES + 40) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
design/c2s_pkg.sv
design/c2s_sqrt_cell.sv
design/c2s_cordic_cell.sv
design/cartesian_to_spherical_core.sv
sim/cartesian_to_spherical_checker.sv
sim/cartesian_to_spherical_core_tb.sv
